[hdl/qrac_pkg.sv]
// Shared widths, types and sine/cosine table builder for the quad rotation unit.
`timescale 1ns / 1ps
package qrac_pkg;

  // Field and datapath widths
  localparam int COORD_W    = 16;
  localparam int ANGLE_W    = 14;
  localparam int TRIG_F     = 15;
  localparam int TRIG_W     = TRIG_F + 2;
  localparam int MAG_W      = TRIG_F + 1;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + TRIG_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int QUOT_W     = SUM_W - TRIG_F;

  // Angle units: 1/16 degree
  localparam int TURN       = 5760;
  localparam int QUARTER    = 1440;
  localparam int EIGHTH     = 720;
  localparam int RED_W      = 13;
  localparam int OFFS_W     = 11;

  // Octant table of {sin, cos}
  localparam int ROM_DEPTH  = EIGHTH + 1;
  localparam int ROM_AW     = $clog2(ROM_DEPTH);
  localparam int ROM_WORD_W = 2 * MAG_W;

  // Pipeline depth: trig result ready after stage five, output after stage eight
  localparam int TRIG_LAT   = 5;
  localparam int PIPE_DEPTH = 8;

  // Saturation bounds
  localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN  = -(1 << (COORD_W - 1));

  // Series constants in Q30
  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint SIN_DIV [5] = '{110, 72, 42, 20, 6};
  localparam longint COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [TRIG_W-1:0]  trig_val_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [ROM_WORD_W-1:0]     rom_word_t;
  typedef logic [ROM_DEPTH-1:0][ROM_WORD_W-1:0] trig_rom_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  // Signed sine and cosine handed to the corner datapaths
  typedef struct packed {
    trig_val_t sin_v;
    trig_val_t cos_v;
  } trig_t;

  // Round a Q30 value half up to TRIG_F fraction bits
  function automatic longint to_trig(longint q30);
    return (q30 + (64'sd1 <<< (29 - TRIG_F))) >>> (30 - TRIG_F);
  endfunction

  // Build the octant table at elaboration: Taylor series in Horner form
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    longint    th;
    longint    t2;
    longint    h;
    longint    s;
    longint    c;
    rom = '0;
    for (int t = 0; t < ROM_DEPTH; t++) begin
      th = (longint'(t) * PI_Q30 + 64'sd1440) / 64'sd2880;
      t2 = (th * th) >>> 30;
      h  = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
        h = Q30_ONE - ((t2 * h) >>> 30) / SIN_DIV[i];
      end
      s = to_trig((th * h) >>> 30);
      h = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
        h = Q30_ONE - ((t2 * h) >>> 30) / COS_DIV[i];
      end
      c = to_trig(h);
      rom[t] = {s[MAG_W-1:0], c[MAG_W-1:0]};
    end
    return rom;
  endfunction

endpackage

[hdl/quad_rotate_about_center_unit.sv]
// Top level: rotates the four corners of a quad about a center point.
//
//   Channel  Handshake              Payload
//   in_      in_valid / in_ready    angle, center, four corners (x, y)
//   out_     out_valid / out_ready  four rotated corners (x, y)
//
// One item per clock when out_ready stays high; the pipeline has eight stages
// (angle wrap, quadrant split, octant fold, table read, sign fix-up, multiply,
// sum, truncate and saturate).
// Reset clears only the stage valid bits; payload registers are not reset.
// When the output register holds an item that is not taken, every stage
// holds and in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module quad_rotate_about_center_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qrac_pkg::angle_t in_angle,
  input  qrac_pkg::coord_t in_center_x,
  input  qrac_pkg::coord_t in_center_y,
  input  qrac_pkg::coord_t in_top_left_x,
  input  qrac_pkg::coord_t in_top_left_y,
  input  qrac_pkg::coord_t in_top_right_x,
  input  qrac_pkg::coord_t in_top_right_y,
  input  qrac_pkg::coord_t in_bottom_right_x,
  input  qrac_pkg::coord_t in_bottom_right_y,
  input  qrac_pkg::coord_t in_bottom_left_x,
  input  qrac_pkg::coord_t in_bottom_left_y,
  output logic             out_valid,
  input  logic             out_ready,
  output qrac_pkg::coord_t out_new_top_left_x,
  output qrac_pkg::coord_t out_new_top_left_y,
  output qrac_pkg::coord_t out_new_top_right_x,
  output qrac_pkg::coord_t out_new_top_right_y,
  output qrac_pkg::coord_t out_new_bottom_right_x,
  output qrac_pkg::coord_t out_new_bottom_right_y,
  output qrac_pkg::coord_t out_new_bottom_left_x,
  output qrac_pkg::coord_t out_new_bottom_left_y
);

  logic                            en;
  logic [qrac_pkg::PIPE_DEPTH-1:0] vld_r;
  qrac_pkg::trig_t                 trig;

  // Advance the whole pipe unless the output item is waiting
  assign en       = !vld_r[qrac_pkg::PIPE_DEPTH-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[qrac_pkg::PIPE_DEPTH-1];

  // Valid bits travel alongside the payload stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[qrac_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  qrac_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .angle (in_angle),
    .trig  (trig)
  );

  qrac_corner u_top_left (
    .clk      (clk),
    .en       (en),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .pt_x     (in_top_left_x),
    .pt_y     (in_top_left_y),
    .trig     (trig),
    .new_x    (out_new_top_left_x),
    .new_y    (out_new_top_left_y)
  );

  qrac_corner u_top_right (
    .clk      (clk),
    .en       (en),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .pt_x     (in_top_right_x),
    .pt_y     (in_top_right_y),
    .trig     (trig),
    .new_x    (out_new_top_right_x),
    .new_y    (out_new_top_right_y)
  );

  qrac_corner u_bottom_right (
    .clk      (clk),
    .en       (en),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .pt_x     (in_bottom_right_x),
    .pt_y     (in_bottom_right_y),
    .trig     (trig),
    .new_x    (out_new_bottom_right_x),
    .new_y    (out_new_bottom_right_y)
  );

  qrac_corner u_bottom_left (
    .clk      (clk),
    .en       (en),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .pt_x     (in_bottom_left_x),
    .pt_y     (in_bottom_left_y),
    .trig     (trig),
    .new_x    (out_new_bottom_left_x),
    .new_y    (out_new_bottom_left_y)
  );

  // Input is only blocked by a waiting output item
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low without a waiting output item");

  // A stall freezes every stage valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // An output item only appears when the stage before held one
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[qrac_pkg::PIPE_DEPTH-2]))
    else $error("output item without a source");

endmodule

[hdl/qrac_trig.sv]
// Angle reduction, octant table lookup and quadrant sign fix-up, five stages.
`timescale 1ns / 1ps
module qrac_trig (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  qrac_pkg::angle_t  angle,
  output qrac_pkg::trig_t   trig
);

  localparam int AX_W = qrac_pkg::ANGLE_W + 2;
  localparam qrac_pkg::trig_rom_t TRIG_ROM = qrac_pkg::build_trig_rom();

  logic signed [AX_W-1:0]          ang_x;
  logic [qrac_pkg::RED_W-1:0]      red_nxt;
  logic [qrac_pkg::RED_W-1:0]      red_r;
  qrac_pkg::quad_t                 quad_nxt;
  logic [qrac_pkg::OFFS_W-1:0]     offs_nxt;
  qrac_pkg::quad_t                 quad2_r;
  logic [qrac_pkg::OFFS_W-1:0]     offs_r;
  logic [qrac_pkg::ROM_AW-1:0]     addr_nxt;
  logic                            swap_nxt;
  logic [qrac_pkg::ROM_AW-1:0]     addr_r;
  logic                            swap3_r;
  qrac_pkg::quad_t                 quad3_r;
  qrac_pkg::rom_word_t             rom_q_r;
  logic                            swap4_r;
  qrac_pkg::quad_t                 quad4_r;
  logic [qrac_pkg::MAG_W-1:0]      s_mag;
  logic [qrac_pkg::MAG_W-1:0]      c_mag;
  qrac_pkg::trig_val_t             s0;
  qrac_pkg::trig_val_t             c0;
  qrac_pkg::trig_t                 trig_nxt;
  qrac_pkg::trig_t                 trig_r;

  // Stage 1: wrap the angle into one turn
  always_comb begin
    ang_x = AX_W'(angle);
    if (ang_x < -qrac_pkg::TURN) begin
      red_nxt = qrac_pkg::RED_W'(ang_x + AX_W'(2 * qrac_pkg::TURN));
    end else if (ang_x < 0) begin
      red_nxt = qrac_pkg::RED_W'(ang_x + AX_W'(qrac_pkg::TURN));
    end else if (ang_x >= qrac_pkg::TURN) begin
      red_nxt = qrac_pkg::RED_W'(ang_x - AX_W'(qrac_pkg::TURN));
    end else begin
      red_nxt = qrac_pkg::RED_W'(ang_x);
    end
  end

  // Stage 2: split into quadrant and offset
  always_comb begin
    if (red_r < qrac_pkg::QUARTER) begin
      quad_nxt = qrac_pkg::QUAD_0;
      offs_nxt = qrac_pkg::OFFS_W'(red_r);
    end else if (red_r < 2 * qrac_pkg::QUARTER) begin
      quad_nxt = qrac_pkg::QUAD_1;
      offs_nxt = qrac_pkg::OFFS_W'(red_r - qrac_pkg::RED_W'(qrac_pkg::QUARTER));
    end else if (red_r < 3 * qrac_pkg::QUARTER) begin
      quad_nxt = qrac_pkg::QUAD_2;
      offs_nxt = qrac_pkg::OFFS_W'(red_r - qrac_pkg::RED_W'(2 * qrac_pkg::QUARTER));
    end else begin
      quad_nxt = qrac_pkg::QUAD_3;
      offs_nxt = qrac_pkg::OFFS_W'(red_r - qrac_pkg::RED_W'(3 * qrac_pkg::QUARTER));
    end
  end

  // Stage 3: fold the upper half of the quadrant onto the first octant
  always_comb begin
    if (offs_r <= qrac_pkg::OFFS_W'(qrac_pkg::EIGHTH)) begin
      addr_nxt = qrac_pkg::ROM_AW'(offs_r);
      swap_nxt = 1'b0;
    end else begin
      addr_nxt = qrac_pkg::ROM_AW'(qrac_pkg::OFFS_W'(qrac_pkg::QUARTER) - offs_r);
      swap_nxt = 1'b1;
    end
  end

  // Stage 5: undo the fold, then apply quadrant signs
  always_comb begin
    s_mag = rom_q_r[qrac_pkg::ROM_WORD_W-1:qrac_pkg::MAG_W];
    c_mag = rom_q_r[qrac_pkg::MAG_W-1:0];
    if (swap4_r) begin
      s0 = $signed({1'b0, c_mag});
      c0 = $signed({1'b0, s_mag});
    end else begin
      s0 = $signed({1'b0, s_mag});
      c0 = $signed({1'b0, c_mag});
    end
    unique case (quad4_r)
      qrac_pkg::QUAD_0: begin
        trig_nxt.sin_v = s0;
        trig_nxt.cos_v = c0;
      end
      qrac_pkg::QUAD_1: begin
        trig_nxt.sin_v = c0;
        trig_nxt.cos_v = -s0;
      end
      qrac_pkg::QUAD_2: begin
        trig_nxt.sin_v = -s0;
        trig_nxt.cos_v = -c0;
      end
      default: begin
        trig_nxt.sin_v = -c0;
        trig_nxt.cos_v = s0;
      end
    endcase
  end

  // Advance all stages together; the table read is registered
  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      quad2_r <= quad_nxt;
      offs_r  <= offs_nxt;
      addr_r  <= addr_nxt;
      swap3_r <= swap_nxt;
      quad3_r <= quad2_r;
      rom_q_r <= TRIG_ROM[addr_r];
      swap4_r <= swap3_r;
      quad4_r <= quad3_r;
      trig_r  <= trig_nxt;
    end
  end

  assign trig = trig_r;

  // Wrapped angle always lies inside one turn
  a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en) |-> red_r < qrac_pkg::TURN)
    else $error("reduced angle out of range");

  // Sine and cosine never exceed one in magnitude
  a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en, 1) && $past(en, 5) |->
      trig_r.sin_v <= (1 <<< qrac_pkg::TRIG_F) && trig_r.sin_v >= -(1 <<< qrac_pkg::TRIG_F)
      && trig_r.cos_v <= (1 <<< qrac_pkg::TRIG_F)
      && trig_r.cos_v >= -(1 <<< qrac_pkg::TRIG_F))
    else $error("trig value beyond unity");

endmodule

[hdl/qrac_corner.sv]
// One corner's rotation datapath: offset, products, sum, truncation and saturation.
`timescale 1ns / 1ps
module qrac_corner (
  input  logic             clk,
  input  logic             en,
  input  qrac_pkg::coord_t center_x,
  input  qrac_pkg::coord_t center_y,
  input  qrac_pkg::coord_t pt_x,
  input  qrac_pkg::coord_t pt_y,
  input  qrac_pkg::trig_t  trig,
  output qrac_pkg::coord_t new_x,
  output qrac_pkg::coord_t new_y
);

  localparam int L = qrac_pkg::TRIG_LAT;

  qrac_pkg::diff_t  dx_sh_r [L];
  qrac_pkg::diff_t  dy_sh_r [L];
  qrac_pkg::coord_t cx_sh_r [L];
  qrac_pkg::coord_t cy_sh_r [L];
  qrac_pkg::prod_t  pxc_r;
  qrac_pkg::prod_t  pys_r;
  qrac_pkg::prod_t  pxs_r;
  qrac_pkg::prod_t  pyc_r;
  qrac_pkg::coord_t cx6_r;
  qrac_pkg::coord_t cy6_r;
  qrac_pkg::sum_t   tx_nxt;
  qrac_pkg::sum_t   ty_nxt;
  qrac_pkg::sum_t   tx_r;
  qrac_pkg::sum_t   ty_r;
  qrac_pkg::coord_t nx_nxt;
  qrac_pkg::coord_t ny_nxt;
  qrac_pkg::coord_t nx_r;
  qrac_pkg::coord_t ny_r;

  // Divide by 2^F truncating toward zero, then clamp to the coordinate range
  function automatic qrac_pkg::coord_t trunc_sat(qrac_pkg::sum_t v);
    logic signed [qrac_pkg::QUOT_W-1:0] quo;
    quo = qrac_pkg::QUOT_W'(v >>> qrac_pkg::TRIG_F);
    if (v[qrac_pkg::SUM_W-1] && (v[qrac_pkg::TRIG_F-1:0] != '0)) begin
      quo = quo + qrac_pkg::QUOT_W'(1);
    end
    if (quo > qrac_pkg::QUOT_W'(qrac_pkg::COORD_MAX)) begin
      return qrac_pkg::coord_t'(qrac_pkg::COORD_MAX);
    end else if (quo < qrac_pkg::QUOT_W'(qrac_pkg::COORD_MIN)) begin
      return qrac_pkg::coord_t'(qrac_pkg::COORD_MIN);
    end
    return qrac_pkg::coord_t'(quo);
  endfunction

  // Stage 7 sums: center in Q(F) plus rotated offsets; stage 8 truncates and saturates the registered sums
  always_comb begin
    tx_nxt = (qrac_pkg::SUM_W'(cx6_r) <<< qrac_pkg::TRIG_F)
           + qrac_pkg::SUM_W'(pxc_r) - qrac_pkg::SUM_W'(pys_r);
    ty_nxt = (qrac_pkg::SUM_W'(cy6_r) <<< qrac_pkg::TRIG_F)
           + qrac_pkg::SUM_W'(pxs_r) + qrac_pkg::SUM_W'(pyc_r);
    nx_nxt = trunc_sat(tx_r);
    ny_nxt = trunc_sat(ty_r);
  end

  // Stage 1 offsets, delay line to meet the trig result, then stages 6 to 8
  always_ff @(posedge clk) begin
    if (en) begin
      dx_sh_r[0] <= qrac_pkg::DIFF_W'(pt_x) - qrac_pkg::DIFF_W'(center_x);
      dy_sh_r[0] <= qrac_pkg::DIFF_W'(pt_y) - qrac_pkg::DIFF_W'(center_y);
      cx_sh_r[0] <= center_x;
      cy_sh_r[0] <= center_y;
      for (int i = 1; i < L; i++) begin
        dx_sh_r[i] <= dx_sh_r[i-1];
        dy_sh_r[i] <= dy_sh_r[i-1];
        cx_sh_r[i] <= cx_sh_r[i-1];
        cy_sh_r[i] <= cy_sh_r[i-1];
      end
      pxc_r <= qrac_pkg::PROD_W'(dx_sh_r[L-1]) * qrac_pkg::PROD_W'(trig.cos_v);
      pys_r <= qrac_pkg::PROD_W'(dy_sh_r[L-1]) * qrac_pkg::PROD_W'(trig.sin_v);
      pxs_r <= qrac_pkg::PROD_W'(dx_sh_r[L-1]) * qrac_pkg::PROD_W'(trig.sin_v);
      pyc_r <= qrac_pkg::PROD_W'(dy_sh_r[L-1]) * qrac_pkg::PROD_W'(trig.cos_v);
      cx6_r <= cx_sh_r[L-1];
      cy6_r <= cy_sh_r[L-1];
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
    end
  end

  assign new_x = nx_r;
  assign new_y = ny_r;

endmodule
